// ----- design/lj_sop_pkg.sv -----
// ----------------------------------------------------------------------------
// lj_sop_pkg
// Shared widths, fixed-point limits and register codes of the pair force unit.
// ----------------------------------------------------------------------------
package lj_sop_pkg;

    // Field and datapath widths
    localparam int Q_W        = 48;
    localparam int HALF_W     = Q_W / 2;
    localparam int PROD_W     = 2 * Q_W;
    localparam int POS_W      = 32;
    localparam int DIFF_W     = POS_W + 1;
    localparam int RSQ_W      = 64;
    localparam int CUT_W      = 47;
    localparam int SPEC_W     = 15;
    localparam int SPEC_FRAC  = 14;
    localparam int POS_FRAC   = 16;
    localparam int DEG_W      = 2;
    localparam int DOM_W      = 16;
    localparam int MOL_W      = 24;

    // Configuration port
    localparam int CFG_ADDR_W  = 6;
    localparam int CFG_IDX_LSB = 3;
    localparam int CFG_DATA_W  = 64;

    // Saturation limits of the 48-bit signed format
    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // Register map, one 64-bit slot per register
    typedef enum logic [2:0] {
        REG_CUTOFF_SQ,
        REG_ATTRACT_FORCE_A,
        REG_ATTRACT_FORCE_B,
        REG_ATTRACT_ENERGY_A,
        REG_ATTRACT_ENERGY_B,
        REG_REPULSE_FORCE,
        REG_REPULSE_ENERGY,
        REG_ENERGY_SHIFT
    } cfg_reg_t;

    // Bond degrees that take the repulsive term
    localparam logic [DEG_W-1:0] DEG_ONE_HOP = 2'd1;
    localparam logic [DEG_W-1:0] DEG_TWO_HOP = 2'd2;

endpackage

// ----- design/lj_sop_if.sv -----
// ----------------------------------------------------------------------------
// lj_sop_if
// Valid/ready channels carrying one neighbor pair and one pair result.
// ----------------------------------------------------------------------------
interface lj_sop_pair_if import lj_sop_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pos_ix;
    logic signed [POS_W-1:0]  pos_iy;
    logic signed [POS_W-1:0]  pos_iz;
    logic signed [POS_W-1:0]  pos_jx;
    logic signed [POS_W-1:0]  pos_jy;
    logic signed [POS_W-1:0]  pos_jz;
    logic [DEG_W-1:0]         bond_degree;
    logic [SPEC_W-1:0]        special_factor;
    logic [DOM_W-1:0]         domain_i;
    logic [DOM_W-1:0]         domain_j;
    logic [MOL_W-1:0]         molecule_i;
    logic [MOL_W-1:0]         molecule_j;

    modport source (
        output valid, pos_ix, pos_iy, pos_iz, pos_jx, pos_jy, pos_jz,
               bond_degree, special_factor, domain_i, domain_j,
               molecule_i, molecule_j,
        input  ready
    );

    modport sink (
        input  valid, pos_ix, pos_iy, pos_iz, pos_jx, pos_jy, pos_jz,
               bond_degree, special_factor, domain_i, domain_j,
               molecule_i, molecule_j,
        output ready
    );

endinterface

interface lj_sop_result_if import lj_sop_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic signed [Q_W-1:0]  force_x;
    logic signed [Q_W-1:0]  force_y;
    logic signed [Q_W-1:0]  force_z;
    logic signed [Q_W-1:0]  pair_energy;
    logic                   in_range;
    logic                   saturated;

    modport source (
        output valid, force_x, force_y, force_z, pair_energy, in_range, saturated,
        input  ready
    );

    modport sink (
        input  valid, force_x, force_y, force_z, pair_energy, in_range, saturated,
        output ready
    );

endinterface

// ----- design/lj_sop_qmul.sv -----
// ----------------------------------------------------------------------------
// lj_sop_qmul
// Pipelined 48x48 signed fixed-point multiply with truncating shift and
// saturation. Three internal register stages; result is combinational off
// the last one.
// ----------------------------------------------------------------------------
module lj_sop_qmul import lj_sop_pkg::*; #(
    parameter int SHIFT = 24
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [Q_W-1:0] a,
    input  logic signed [Q_W-1:0] b,
    output logic signed [Q_W-1:0] p,
    output logic                  sat
);

    logic [Q_W-1:0]    mag_a_reg;
    logic [Q_W-1:0]    mag_b_reg;
    logic [Q_W-1:0]    mag_a_next;
    logic [Q_W-1:0]    mag_b_next;
    logic              neg1_reg;
    logic              neg2_reg;
    logic              neg3_reg;
    logic [Q_W-1:0]    pp_ll_reg;
    logic [Q_W-1:0]    pp_lh_reg;
    logic [Q_W-1:0]    pp_hl_reg;
    logic [Q_W-1:0]    pp_hh_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] shifted;
    logic [PROD_W-1:0] lim;
    logic [Q_W-1:0]    mag_out;

    // Take magnitudes and product sign
    assign mag_a_next = a[Q_W-1] ? Q_W'(~a + 1'b1) : Q_W'(a);
    assign mag_b_next = b[Q_W-1] ? Q_W'(~b + 1'b1) : Q_W'(b);

    // Sum the four half-width partial products
    assign prod_next = {pp_hh_reg, pp_ll_reg}
                     + (PROD_W'(pp_lh_reg) << HALF_W)
                     + (PROD_W'(pp_hl_reg) << HALF_W);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_a_reg <= mag_a_next;
            mag_b_reg <= mag_b_next;
            neg1_reg  <= a[Q_W-1] ^ b[Q_W-1];
            pp_ll_reg <= Q_W'(mag_a_reg[HALF_W-1:0]) * Q_W'(mag_b_reg[HALF_W-1:0]);
            pp_lh_reg <= Q_W'(mag_a_reg[HALF_W-1:0]) * Q_W'(mag_b_reg[Q_W-1:HALF_W]);
            pp_hl_reg <= Q_W'(mag_a_reg[Q_W-1:HALF_W]) * Q_W'(mag_b_reg[HALF_W-1:0]);
            pp_hh_reg <= Q_W'(mag_a_reg[Q_W-1:HALF_W]) * Q_W'(mag_b_reg[Q_W-1:HALF_W]);
            neg2_reg  <= neg1_reg;
            prod_reg  <= prod_next;
            neg3_reg  <= neg2_reg;
        end
    end

    // Drop fraction bits, clip magnitude, restore sign
    always_comb
    begin
        shifted = prod_reg >> SHIFT;
        lim     = neg3_reg ? PROD_W'($unsigned(Q_MIN)) : PROD_W'($unsigned(Q_MAX));
        sat     = shifted > lim;
        mag_out = sat ? lim[Q_W-1:0] : shifted[Q_W-1:0];
        p       = neg3_reg ? -$signed(mag_out) : $signed(mag_out);
    end

endmodule

// ----- design/lj_sop_recip.sv -----
// ----------------------------------------------------------------------------
// lj_sop_recip
// Pipelined restoring divider for floor(2^(2*FRAC_BITS) / den), one quotient
// bit per stage, saturated to the 48-bit signed maximum.
// ----------------------------------------------------------------------------
module lj_sop_recip import lj_sop_pkg::*; #(
    parameter int FRAC_BITS = 24
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [RSQ_W-1:0]      den,
    output logic signed [Q_W-1:0] q,
    output logic                  sat
);

    localparam int NSTEP = 2 * FRAC_BITS + 1;
    localparam int QW    = NSTEP;

    logic [RSQ_W-1:0] rem_reg  [NSTEP];
    logic [RSQ_W-1:0] den_reg  [NSTEP];
    logic [QW-1:0]    quo_reg  [NSTEP];
    logic [RSQ_W-1:0] rem_next [NSTEP];
    logic [RSQ_W-1:0] den_next [NSTEP];
    logic [QW-1:0]    quo_next [NSTEP];
    logic [RSQ_W:0]   quo_ext;

    // One restoring step per stage; the dividend is a single one bit on top
    always_comb
    begin
        logic [RSQ_W:0]   trial;
        logic [RSQ_W-1:0] rem_in;
        logic [RSQ_W-1:0] den_in;
        logic [QW-1:0]    quo_in;
        logic             bit_in;
        logic             take;
        for (int k = 0; k < NSTEP; k++)
        begin
            if (k == 0)
            begin
                rem_in = '0;
                den_in = den;
                quo_in = '0;
                bit_in = 1'b1;
            end
            else
            begin
                rem_in = rem_reg[k-1];
                den_in = den_reg[k-1];
                quo_in = quo_reg[k-1];
                bit_in = 1'b0;
            end
            trial       = {rem_in, bit_in};
            take        = trial >= {1'b0, den_in};
            rem_next[k] = take ? RSQ_W'(trial - {1'b0, den_in}) : trial[RSQ_W-1:0];
            den_next[k] = den_in;
            quo_next[k] = {quo_in[QW-2:0], take};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NSTEP; k++)
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_next[k];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    // Clip the quotient to the signed 48-bit range
    assign quo_ext = (RSQ_W+1)'(quo_reg[NSTEP-1]);
    assign sat     = |quo_ext[RSQ_W:Q_W-1];
    assign q       = sat ? Q_MAX : $signed(quo_ext[Q_W-1:0]);

endmodule

// ----- design/lj_pair_force_sop_top.sv -----
// ----------------------------------------------------------------------------
// lj_pair_force_sop_top
// Lennard-Jones pair force and energy for one neighbor pair, fixed point.
// Throughput: one pair per cycle while the output skid is empty; depth is
// set by the 2*FRAC_BITS+1 stage reciprocal unit and the multiplier chain
// behind it.
// Reset clears the config registers, valid bits and skid flag; no clearing pass.
// ----------------------------------------------------------------------------
module lj_pair_force_sop_top import lj_sop_pkg::*; #(
    parameter int FRAC_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    lj_sop_pair_if.sink           pair_ch,
    lj_sop_result_if.source       result_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int NSTEP    = 2 * FRAC_BITS + 1;
    localparam int SQ_SHIFT = 32 - FRAC_BITS;
    localparam int ST_R2INV = NSTEP + 4;
    localparam int ST_R2SQ  = ST_R2INV + 4;
    localparam int ST_R6    = ST_R2SQ + 4;
    localparam int ST_COEF  = ST_R6 + 4;
    localparam int ST_DIFF  = ST_COEF + 1;
    localparam int ST_POLY  = ST_DIFF + 4;
    localparam int ST_SEL   = ST_POLY + 1;
    localparam int ST_SCALE = ST_SEL + 4;
    localparam int ST_MERGE = ST_SCALE + 1;
    localparam int ST_FPAIR = ST_SCALE + 4;
    localparam int LAST     = ST_FPAIR + 4;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
        logic [SPEC_W-1:0]        special;
        logic                     rep;
        logic                     nb_ok;
        logic                     in_range;
        logic                     sat;
        logic                     sat_rep;
        logic                     sat_nb;
        logic signed [Q_W-1:0]    r2inv;
        logic signed [Q_W-1:0]    r2sq;
        logic signed [Q_W-1:0]    r6;
        logic signed [Q_W-1:0]    rep_f;
        logic signed [Q_W-1:0]    rep_e;
        logic signed [Q_W-1:0]    af;
        logic signed [Q_W-1:0]    ae;
        logic signed [Q_W-1:0]    tf;
        logic signed [Q_W-1:0]    te;
        logic signed [Q_W-1:0]    f_nb;
        logic signed [Q_W-1:0]    ae2;
        logic signed [Q_W-1:0]    te3;
        logic signed [Q_W-1:0]    f;
        logic signed [Q_W-1:0]    sf;
        logic signed [Q_W-1:0]    e_nb;
        logic signed [Q_W-1:0]    e;
        logic signed [Q_W-1:0]    fp;
        logic signed [Q_W-1:0]    fx;
        logic signed [Q_W-1:0]    fy;
        logic signed [Q_W-1:0]    fz;
    } side_t;

    typedef struct packed {
        logic signed [Q_W-1:0] force_x;
        logic signed [Q_W-1:0] force_y;
        logic signed [Q_W-1:0] force_z;
        logic signed [Q_W-1:0] pair_energy;
        logic                  in_range;
        logic                  saturated;
    } result_t;

    // Saturating subtract: {sat, value}
    function automatic logic [Q_W:0] sub_sat(input logic signed [Q_W-1:0] x,
                                             input logic signed [Q_W-1:0] y);
        logic signed [Q_W:0] diff;
        logic [Q_W:0]        res;
        diff = {x[Q_W-1], x} - {y[Q_W-1], y};
        if (diff[Q_W] != diff[Q_W-1])
        begin
            res = {1'b1, (diff[Q_W] ? Q_MIN : Q_MAX)};
        end
        else
        begin
            res = {1'b0, diff[Q_W-1:0]};
        end
        return res;
    endfunction

    // Configuration registers
    logic [CUT_W-1:0]      cutoff_sq_reg;
    logic signed [Q_W-1:0] attract_force_a_reg;
    logic signed [Q_W-1:0] attract_force_b_reg;
    logic signed [Q_W-1:0] attract_energy_a_reg;
    logic signed [Q_W-1:0] attract_energy_b_reg;
    logic signed [Q_W-1:0] repulse_force_reg;
    logic signed [Q_W-1:0] repulse_energy_reg;
    logic signed [Q_W-1:0] energy_shift_reg;
    cfg_reg_t              cfg_sel;
    logic                  cfg_write;

    // Pipeline state
    logic                  en;
    logic [LAST:1]         v_reg;
    side_t                 st_reg  [1:LAST];
    side_t                 st_next [1:LAST];
    logic [RSQ_W-1:0]      sq_reg  [3];
    logic [RSQ_W-1:0]      sq_next [3];
    logic [RSQ_W-1:0]      rsq_reg;
    logic [RSQ_W-1:0]      rsq_next;
    logic [RSQ_W+1:0]      rsq_sum;
    logic [Q_W:0]          tf_res;
    logic [Q_W:0]          te_res;
    logic [Q_W:0]          te3_res;

    // Unit outputs
    logic signed [Q_W-1:0] div_q;
    logic                  div_sat;
    logic signed [Q_W-1:0] r2sq_p, r6_p, rf_p, re_p, af_p, ae_p, fnb_p, ae2_p;
    logic signed [Q_W-1:0] sf_p, enb_p, fp_p, fx_p, fy_p, fz_p;
    logic                  r2sq_s, r6_s, rf_s, re_s, af_s, ae_s, fnb_s, ae2_s;
    logic                  sf_s, enb_s, fp_s, fx_s, fy_s, fz_s;

    // Output skid
    logic                  skid_full_reg;
    logic                  skid_full_next;
    result_t               skid_data_reg;
    result_t               out_now;
    result_t               out_sel;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_sel   = cfg_reg_t'(paddr[CFG_ADDR_W-1:CFG_IDX_LSB]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_sq_reg        <= '0;
            attract_force_a_reg  <= '0;
            attract_force_b_reg  <= '0;
            attract_energy_a_reg <= '0;
            attract_energy_b_reg <= '0;
            repulse_force_reg    <= '0;
            repulse_energy_reg   <= '0;
            energy_shift_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_CUTOFF_SQ:        cutoff_sq_reg        <= pwdata[CUT_W-1:0];
                REG_ATTRACT_FORCE_A:  attract_force_a_reg  <= pwdata[Q_W-1:0];
                REG_ATTRACT_FORCE_B:  attract_force_b_reg  <= pwdata[Q_W-1:0];
                REG_ATTRACT_ENERGY_A: attract_energy_a_reg <= pwdata[Q_W-1:0];
                REG_ATTRACT_ENERGY_B: attract_energy_b_reg <= pwdata[Q_W-1:0];
                REG_REPULSE_FORCE:    repulse_force_reg    <= pwdata[Q_W-1:0];
                REG_REPULSE_ENERGY:   repulse_energy_reg   <= pwdata[Q_W-1:0];
                REG_ENERGY_SHIFT:     energy_shift_reg     <= pwdata[Q_W-1:0];
            endcase
        end
    end

    // Read back, signed registers sign-extended
    always_comb
    begin
        unique case (cfg_sel)
            REG_CUTOFF_SQ:        prdata = CFG_DATA_W'(cutoff_sq_reg);
            REG_ATTRACT_FORCE_A:  prdata = CFG_DATA_W'(attract_force_a_reg);
            REG_ATTRACT_FORCE_B:  prdata = CFG_DATA_W'(attract_force_b_reg);
            REG_ATTRACT_ENERGY_A: prdata = CFG_DATA_W'(attract_energy_a_reg);
            REG_ATTRACT_ENERGY_B: prdata = CFG_DATA_W'(attract_energy_b_reg);
            REG_REPULSE_FORCE:    prdata = CFG_DATA_W'(repulse_force_reg);
            REG_REPULSE_ENERGY:   prdata = CFG_DATA_W'(repulse_energy_reg);
            REG_ENERGY_SHIFT:     prdata = CFG_DATA_W'(energy_shift_reg);
        endcase
    end

    // ------------------------------------------------------------------------
    // Pipeline advance: hold everything only while the skid is occupied
    // ------------------------------------------------------------------------
    assign en            = !skid_full_reg;
    assign pair_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAST-1:1], pair_ch.valid};
        end
    end

    // Squared distance: square each axis, then saturating sum
    always_comb
    begin
        logic [DIFF_W-1:0] mag;
        for (int k = 0; k < 3; k++)
        begin
            unique case (k)
                0:       mag = st_reg[1].dx[DIFF_W-1] ? -st_reg[1].dx : st_reg[1].dx;
                1:       mag = st_reg[1].dy[DIFF_W-1] ? -st_reg[1].dy : st_reg[1].dy;
                default: mag = st_reg[1].dz[DIFF_W-1] ? -st_reg[1].dz : st_reg[1].dz;
            endcase
            sq_next[k] = RSQ_W'(mag[POS_W-1:0]) * RSQ_W'(mag[POS_W-1:0]);
        end
        rsq_sum  = (RSQ_W+2)'(sq_reg[0] >> SQ_SHIFT)
                 + (RSQ_W+2)'(sq_reg[1] >> SQ_SHIFT)
                 + (RSQ_W+2)'(sq_reg[2] >> SQ_SHIFT);
        rsq_next = (|rsq_sum[RSQ_W+1:RSQ_W]) ? '1 : rsq_sum[RSQ_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= sq_next[k];
            end
            rsq_reg <= rsq_next;
        end
    end

    // ------------------------------------------------------------------------
    // Arithmetic units
    // ------------------------------------------------------------------------
    lj_sop_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
        .clk(clk), .en(en), .den(rsq_reg), .q(div_q), .sat(div_sat)
    );

    lj_sop_qmul #(.SHIFT(FRAC_BITS)) u_r2sq (
        .clk(clk), .en(en), .a(st_reg[ST_R2INV].r2inv), .b(st_reg[ST_R2INV].r2inv),
        .p(r2sq_p), .sat(r2sq_s)
    );

    lj_sop_qmul #(.SHIFT(FRAC_BITS)) u_r6 (
        .clk(clk), .en(en), .a(st_reg[ST_R2SQ].r2sq), .b(st_reg[ST_R2SQ].r2inv),
        .p(r6_p), .sat(r6_s)
    );

    lj_sop_qmul #(.SHIFT(FRAC_BITS)) u_rep_f (
        .clk(clk), .en(en), .a(st_reg[ST_R6].r6), .b(repulse_force_reg),
        .p(rf_p), .sat(rf_s)
    );

    lj_sop_qmul #(.SHIFT(FRAC_BITS)) u_rep_e (
        .clk(clk), .en(en), .a(st_reg[ST_R6].r6), .b(repulse_energy_reg),
        .p(re_p), .sat(re_s)
    );

    lj_sop_qmul #(.SHIFT(FRAC_BITS)) u_att_f (
        .clk(clk), .en(en), .a(attract_force_a_reg), .b(st_reg[ST_R6].r6),
        .p(af_p), .sat(af_s)
    );

    lj_sop_qmul #(.SHIFT(FRAC_BITS)) u_att_e (
        .clk(clk), .en(en), .a(attract_energy_a_reg), .b(st_reg[ST_R6].r6),
        .p(ae_p), .sat(ae_s)
    );

    lj_sop_qmul #(.SHIFT(FRAC_BITS)) u_poly_f (
        .clk(clk), .en(en), .a(st_reg[ST_DIFF].r6), .b(st_reg[ST_DIFF].tf),
        .p(fnb_p), .sat(fnb_s)
    );

    lj_sop_qmul #(.SHIFT(FRAC_BITS)) u_poly_e (
        .clk(clk), .en(en), .a(st_reg[ST_DIFF].r6), .b(st_reg[ST_DIFF].te),
        .p(ae2_p), .sat(ae2_s)
    );

    lj_sop_qmul #(.SHIFT(SPEC_FRAC)) u_spec_f (
        .clk(clk), .en(en),
        .a({{(Q_W-SPEC_W){1'b0}}, st_reg[ST_SEL].special}), .b(st_reg[ST_SEL].f),
        .p(sf_p), .sat(sf_s)
    );

    lj_sop_qmul #(.SHIFT(SPEC_FRAC)) u_spec_e (
        .clk(clk), .en(en),
        .a({{(Q_W-SPEC_W){1'b0}}, st_reg[ST_SEL].special}), .b(st_reg[ST_SEL].te3),
        .p(enb_p), .sat(enb_s)
    );

    lj_sop_qmul #(.SHIFT(FRAC_BITS)) u_fpair (
        .clk(clk), .en(en), .a(st_reg[ST_SCALE].sf), .b(st_reg[ST_SCALE].r2inv),
        .p(fp_p), .sat(fp_s)
    );

    lj_sop_qmul #(.SHIFT(POS_FRAC)) u_force_x (
        .clk(clk), .en(en),
        .a({{(Q_W-DIFF_W){st_reg[ST_FPAIR].dx[DIFF_W-1]}}, st_reg[ST_FPAIR].dx}),
        .b(st_reg[ST_FPAIR].fp), .p(fx_p), .sat(fx_s)
    );

    lj_sop_qmul #(.SHIFT(POS_FRAC)) u_force_y (
        .clk(clk), .en(en),
        .a({{(Q_W-DIFF_W){st_reg[ST_FPAIR].dy[DIFF_W-1]}}, st_reg[ST_FPAIR].dy}),
        .b(st_reg[ST_FPAIR].fp), .p(fy_p), .sat(fy_s)
    );

    lj_sop_qmul #(.SHIFT(POS_FRAC)) u_force_z (
        .clk(clk), .en(en),
        .a({{(Q_W-DIFF_W){st_reg[ST_FPAIR].dz[DIFF_W-1]}}, st_reg[ST_FPAIR].dz}),
        .b(st_reg[ST_FPAIR].fp), .p(fz_p), .sat(fz_s)
    );

    assign tf_res  = sub_sat(st_reg[ST_COEF].af, attract_force_b_reg);
    assign te_res  = sub_sat(st_reg[ST_COEF].ae, attract_energy_b_reg);
    assign te3_res = sub_sat(st_reg[ST_POLY].ae2, energy_shift_reg);

    // ------------------------------------------------------------------------
    // Sideband: advance each stage, then drop unit results into their slots
    // ------------------------------------------------------------------------
    always_comb
    begin
        for (int s = 2; s <= LAST; s++)
        begin
            st_next[s] = st_reg[s-1];
        end

        // Capture the pair
        st_next[1]          = '0;
        st_next[1].dx       = {pair_ch.pos_ix[POS_W-1], pair_ch.pos_ix}
                            - {pair_ch.pos_jx[POS_W-1], pair_ch.pos_jx};
        st_next[1].dy       = {pair_ch.pos_iy[POS_W-1], pair_ch.pos_iy}
                            - {pair_ch.pos_jy[POS_W-1], pair_ch.pos_jy};
        st_next[1].dz       = {pair_ch.pos_iz[POS_W-1], pair_ch.pos_iz}
                            - {pair_ch.pos_jz[POS_W-1], pair_ch.pos_jz};
        st_next[1].special  = pair_ch.special_factor;
        st_next[1].rep      = (pair_ch.bond_degree == DEG_ONE_HOP)
                           || (pair_ch.bond_degree == DEG_TWO_HOP);
        st_next[1].nb_ok    = (pair_ch.domain_i == '0) || (pair_ch.domain_j == '0)
                           || (pair_ch.molecule_i != pair_ch.molecule_j)
                           || (pair_ch.domain_i != pair_ch.domain_j);

        // Cutoff test
        st_next[4].in_range = rsq_reg < RSQ_W'(cutoff_sq_reg);

        // Reciprocal of squared distance
        st_next[ST_R2INV].r2inv = div_q;
        st_next[ST_R2INV].sat   = st_next[ST_R2INV].sat | div_sat;

        // Powers of r^-2
        st_next[ST_R2SQ].r2sq = r2sq_p;
        st_next[ST_R2SQ].sat  = st_next[ST_R2SQ].sat | r2sq_s;
        st_next[ST_R6].r6     = r6_p;
        st_next[ST_R6].sat    = st_next[ST_R6].sat | r6_s;

        // Coefficient products for both branches
        st_next[ST_COEF].rep_f   = rf_p;
        st_next[ST_COEF].rep_e   = re_p;
        st_next[ST_COEF].af      = af_p;
        st_next[ST_COEF].ae      = ae_p;
        st_next[ST_COEF].sat_rep = st_next[ST_COEF].sat_rep | rf_s | re_s;
        st_next[ST_COEF].sat_nb  = st_next[ST_COEF].sat_nb | af_s | ae_s;

        // Subtract r^-6 coefficients
        st_next[ST_DIFF].tf     = tf_res[Q_W-1:0];
        st_next[ST_DIFF].te     = te_res[Q_W-1:0];
        st_next[ST_DIFF].sat_nb = st_next[ST_DIFF].sat_nb | tf_res[Q_W] | te_res[Q_W];

        // Nonbonded polynomial
        st_next[ST_POLY].f_nb   = fnb_p;
        st_next[ST_POLY].ae2    = ae2_p;
        st_next[ST_POLY].sat_nb = st_next[ST_POLY].sat_nb | fnb_s | ae2_s;

        // Energy shift and force select
        st_next[ST_SEL].te3    = te3_res[Q_W-1:0];
        st_next[ST_SEL].sat_nb = st_next[ST_SEL].sat_nb | te3_res[Q_W];
        if (st_reg[ST_POLY].rep)
        begin
            st_next[ST_SEL].f = st_reg[ST_POLY].rep_f;
        end
        else if (st_reg[ST_POLY].nb_ok)
        begin
            st_next[ST_SEL].f = st_reg[ST_POLY].f_nb;
        end
        else
        begin
            st_next[ST_SEL].f = '0;
        end

        // Special-bond scaling
        st_next[ST_SCALE].sf     = sf_p;
        st_next[ST_SCALE].sat    = st_next[ST_SCALE].sat | sf_s;
        st_next[ST_SCALE].e_nb   = enb_p;
        st_next[ST_SCALE].sat_nb = st_next[ST_SCALE].sat_nb | enb_s;

        // Energy select and fold in the flags of the taken branch
        if (st_reg[ST_SCALE].rep)
        begin
            st_next[ST_MERGE].e   = st_reg[ST_SCALE].rep_e;
            st_next[ST_MERGE].sat = st_next[ST_MERGE].sat | st_reg[ST_SCALE].sat_rep;
        end
        else if (st_reg[ST_SCALE].nb_ok)
        begin
            st_next[ST_MERGE].e   = st_reg[ST_SCALE].e_nb;
            st_next[ST_MERGE].sat = st_next[ST_MERGE].sat | st_reg[ST_SCALE].sat_nb;
        end
        else
        begin
            st_next[ST_MERGE].e = '0;
        end

        // Scalar pair force
        st_next[ST_FPAIR].fp  = fp_p;
        st_next[ST_FPAIR].sat = st_next[ST_FPAIR].sat | fp_s;

        // Force components
        st_next[LAST].fx  = fx_p;
        st_next[LAST].fy  = fy_p;
        st_next[LAST].fz  = fz_p;
        st_next[LAST].sat = st_next[LAST].sat | fx_s | fy_s | fz_s;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 1; s <= LAST; s++)
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output: zero everything outside the cutoff, skid on stall
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (st_reg[LAST].in_range)
        begin
            out_now.force_x     = st_reg[LAST].fx;
            out_now.force_y     = st_reg[LAST].fy;
            out_now.force_z     = st_reg[LAST].fz;
            out_now.pair_energy = st_reg[LAST].e;
            out_now.in_range    = 1'b1;
            out_now.saturated   = st_reg[LAST].sat;
        end
        else
        begin
            out_now = '0;
        end
        out_sel = skid_full_reg ? skid_data_reg : out_now;
    end

    always_comb
    begin
        if (skid_full_reg)
        begin
            skid_full_next = !result_ch.ready;
        end
        else
        begin
            skid_full_next = v_reg[LAST] && !result_ch.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg)
        begin
            skid_data_reg <= out_now;
        end
    end

    assign result_ch.valid       = skid_full_reg || v_reg[LAST];
    assign result_ch.force_x     = out_sel.force_x;
    assign result_ch.force_y     = out_sel.force_y;
    assign result_ch.force_z     = out_sel.force_z;
    assign result_ch.pair_energy = out_sel.pair_energy;
    assign result_ch.in_range    = out_sel.in_range;
    assign result_ch.saturated   = out_sel.saturated;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && !result_ch.in_range |->
            !result_ch.saturated && result_ch.pair_energy == '0
            && result_ch.force_x == '0 && result_ch.force_y == '0
            && result_ch.force_z == '0)
        else $error("out-of-range result not cleared");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(v_reg[LAST] && !result_ch.ready))
        else $error("skid filled without a stalled result");

    a_r2inv_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_R2INV] |-> !st_reg[ST_R2INV].r2inv[Q_W-1])
        else $error("reciprocal went negative");

    a_r6_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[ST_R6] |-> !st_reg[ST_R6].r6[Q_W-1])
        else $error("r^-6 went negative");

endmodule
